[rtl/swm_pkg.sv]
// Shared constants and the control type for the sliding window maximum block.
`default_nettype none
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_W            = 7;
  localparam int OUT_W            = 32;

  typedef struct packed {
    logic accept;
    logic clear;
    logic drop_front;
    logic shift_only;
  } swm_ctrl_t;

endpackage
`default_nettype wire

[rtl/swm_cell.sv]
// One deque cell: holds a (value, position) entry and moves toward the front.
`default_nettype none
module swm_cell import swm_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire swm_ctrl_t                                  ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0]             sample,
  input  wire logic [$clog2(2*WINDOW_MAX)-1:0]            pos_in,
  input  wire logic [$clog2(2*WINDOW_MAX)-1:0]            pc,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]            k,
  input  wire logic                                       prev_kept,
  input  wire logic                                       right_valid,
  input  wire logic                                       right_kept,
  input  wire logic signed [SAMPLE_WIDTH-1:0]             right_value,
  input  wire logic [$clog2(2*WINDOW_MAX)-1:0]            right_pos,
  output logic                                            valid_o,
  output logic                                            kept_o,
  output logic                                            exp_o,
  output logic signed [SAMPLE_WIDTH-1:0]                  value_o,
  output logic [$clog2(2*WINDOW_MAX)-1:0]                 pos_o
);

  localparam int PW      = $clog2(2*WINDOW_MAX);
  localparam int KW      = $clog2(WINDOW_MAX+1);
  localparam int CW      = PW + KW;
  localparam int POS_MOD = 2*WINDOW_MAX;

  logic                           valid_r, valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] value_r, value_nxt;
  logic [PW-1:0]                  pos_r, pos_nxt;
  logic [PW:0]                    diff, wrapped;
  logic [PW-1:0]                  age;
  logic                           expired;
  logic                           kept;
  logic                           src_kept;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic [PW-1:0]                  src_pos;

  // age modulo 2*WINDOW_MAX
  assign diff    = {1'b0, pc} - {1'b0, pos_r};
  assign wrapped = diff + (PW+1)'(POS_MOD);
  assign age     = diff[PW] ? wrapped[PW-1:0] : diff[PW-1:0];
  assign expired = valid_r & (CW'(age) >= CW'(k));

  assign kept = valid_r & ~expired & ~ctrl.clear & ~(value_r < sample);

  assign src_kept  = ctrl.drop_front ? right_kept  : kept;
  assign src_value = ctrl.drop_front ? right_value : value_r;
  assign src_pos   = ctrl.drop_front ? right_pos   : pos_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    pos_nxt   = pos_r;
    if (ctrl.shift_only) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
      pos_nxt   = right_pos;
    end else if (ctrl.accept) begin
      if (src_kept) begin
        valid_nxt = 1'b1;
        value_nxt = src_value;
        pos_nxt   = src_pos;
      end else if (prev_kept) begin
        valid_nxt = 1'b1;
        value_nxt = sample;
        pos_nxt   = pos_in;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
  end

  assign valid_o = valid_r;
  assign kept_o  = kept;
  assign exp_o   = expired;
  assign value_o = value_r;
  assign pos_o   = pos_r;

endmodule
`default_nettype wire

[rtl/sliding_window_maximum.sv]
// Sliding window maximum: top level with the cell chain, counters and result register.
//
// Input transaction: in_sample_value plus in_start_of_sequence on in_valid/in_ready.
// A set start flag empties the deque and restarts the counts before the sample.
// Output transaction: out_window_max on out_valid/out_ready, produced once
// window_size samples have arrived since the last start; otherwise none.
// Configuration: cfg_wr_en writes cfg_wr_data into window_size at once,
// clamped in use to 1..WINDOW_MAX.
// The deque is a chain of WINDOW_MAX cells, front at cell 0, that shifts one
// place toward the front when the front entry leaves the window.
// Throughput: one transaction per cycle while the output is free and no purge runs.
// After the window shrinks, extra expired front entries shift out before new input.
// The result is registered and shows in the cycle after acceptance.
// A new transaction is taken while a result waits, as long as out_ready frees
// the output register in the same cycle; a stalled receiver holds in_ready low.
// Reset (synchronous, rst_n low) empties the deque, clears the counters and
// sets window_size to 1.
`default_nettype none
module sliding_window_maximum import swm_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_value,
  input  wire logic                           in_start_of_sequence,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [OUT_W-1:0]             out_window_max,
  input  wire logic                           cfg_wr_en,
  input  wire logic [CFG_W-1:0]               cfg_wr_data
);

  localparam int PW      = $clog2(2*WINDOW_MAX);
  localparam int KW      = $clog2(WINDOW_MAX+1);
  localparam int EW      = CFG_W + KW;
  localparam int POS_MOD = 2*WINDOW_MAX;

  logic [CFG_W-1:0]               window_size_r;
  logic [EW-1:0]                  ws_ext;
  logic [KW-1:0]                  k;
  logic [PW-1:0]                  pc_r, pc_nxt;
  logic [KW-1:0]                  fill_r, fill_nxt, fill_base;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] front_r, front_nxt;
  logic                           accept;
  logic                           drop_front;
  logic                           purge;
  logic                           emit;
  logic [PW-1:0]                  pos_in;
  swm_ctrl_t                      ctrl;

  logic [WINDOW_MAX:0]            c_valid, c_kept, c_exp;
  logic signed [SAMPLE_WIDTH-1:0] c_value [WINDOW_MAX+1];
  logic [PW-1:0]                  c_pos   [WINDOW_MAX+1];
  logic [WINDOW_MAX-1:0]          prev_kept;

  assign ws_ext = EW'(window_size_r);
  always_comb begin
    if (window_size_r == '0) begin
      k = KW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = ws_ext[KW-1:0];
    end
  end

  assign drop_front = c_valid[0] & c_exp[0];
  assign purge      = drop_front & c_valid[1] & c_exp[1];
  assign in_ready   = ~purge & (~out_valid_r | out_ready);
  assign accept     = in_valid & in_ready;

  assign ctrl.accept     = accept;
  assign ctrl.clear      = in_start_of_sequence;
  assign ctrl.drop_front = drop_front;
  assign ctrl.shift_only = purge;

  assign pos_in = in_start_of_sequence ? '0 : pc_r;

  // tail beyond the last cell
  assign c_valid[WINDOW_MAX] = 1'b0;
  assign c_kept[WINDOW_MAX]  = 1'b0;
  assign c_exp[WINDOW_MAX]   = 1'b0;
  assign c_value[WINDOW_MAX] = '0;
  assign c_pos[WINDOW_MAX]   = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_kept[i] = 1'b1;
    end else begin : g_rest
      assign prev_kept[i] = drop_front ? c_kept[i] : c_kept[i-1];
    end

    swm_cell #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (in_sample_value),
      .pos_in      (pos_in),
      .pc          (pc_r),
      .k           (k),
      .prev_kept   (prev_kept[i]),
      .right_valid (c_valid[i+1]),
      .right_kept  (c_kept[i+1]),
      .right_value (c_value[i+1]),
      .right_pos   (c_pos[i+1]),
      .valid_o     (c_valid[i]),
      .kept_o      (c_kept[i]),
      .exp_o       (c_exp[i]),
      .value_o     (c_value[i]),
      .pos_o       (c_pos[i])
    );
  end

  always_comb begin
    if (drop_front ? c_kept[1] : c_kept[0]) begin
      front_nxt = drop_front ? c_value[1] : c_value[0];
    end else begin
      front_nxt = in_sample_value;
    end
  end

  assign fill_base = in_start_of_sequence ? '0 : fill_r;
  assign emit      = (fill_nxt >= k);

  always_comb begin
    pc_nxt        = pc_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      pc_nxt        = (pos_in == PW'(POS_MOD-1)) ? '0 : pos_in + PW'(1);
      fill_nxt      = (fill_base == KW'(WINDOW_MAX)) ? fill_base : fill_base + KW'(1);
      out_valid_nxt = (((fill_base == KW'(WINDOW_MAX)) ? fill_base : fill_base + KW'(1))
                       >= k);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_W'(1);
      pc_r          <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size_r <= cfg_wr_data;
      end
      pc_r        <= pc_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept && emit) begin
      front_r <= front_nxt;
    end
  end

  assign out_valid = out_valid_r;

  if (SAMPLE_WIDTH >= OUT_W) begin : g_out_trunc
    assign out_window_max = front_r[OUT_W-1:0];
  end else begin : g_out_ext
    assign out_window_max = {{(OUT_W-SAMPLE_WIDTH){1'b0}}, front_r};
  end

endmodule
`default_nettype wire
